@@ design/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 8;
    localparam int COUNT_W = 5;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_spq_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_spq_status;

    typedef struct packed {
        t_spq_op             opcode;
        logic [PRIO_W-1:0]   priority_req;
        logic [TAG_W-1:0]    item_tag;
    } t_spq_in;

    typedef struct packed {
        t_spq_status         status;
        logic [TAG_W-1:0]    out_tag;
        logic [PRIO_W-1:0]   out_priority;
        logic [COUNT_W-1:0]  count;
    } t_spq_out;

    // One held entry
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [TAG_W-1:0]    tag;
    } t_spq_entry;

    // Broadcast to every cell for one beat
    typedef struct packed {
        logic                push;   // accepted push, queue not full
        logic                pop;    // accepted pop, queue not empty
        t_spq_entry          item;   // entry carried by a push
    } t_spq_ctrl;

endpackage

@@ design/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: a row of spq_cell slots plus the
// entry counter and the result register. Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

//  Channel | Valid      | Stall       | Payload
//  input   | i_in_valid | o_in_stall  | i_in_data  (spq_pkg::t_spq_in)
//  result  | o_out_valid| i_out_stall | o_out_data (spq_pkg::t_spq_out)
//
// One beat per cycle while not stalled: a push or pop updates every slot together,
// each slot comparing its own priority and taking from a neighbor; the result shows in
// the cycle after the input beat. Synchronous active-low reset empties the queue
// and clears the result valid. Input stalls only while a result waits unclaimed.

module sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_spq_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_spq_out  o_out_data
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = (CNT_W > spq_pkg::COUNT_W) ? CNT_W : spq_pkg::COUNT_W;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    spq_pkg::t_spq_out   r_out;
    spq_pkg::t_spq_out   n_out;

    logic                in_beat;
    logic                is_pop;
    logic                full;
    logic                empty;
    logic [WIDE_W-1:0]   count_wide;
    spq_pkg::t_spq_ctrl  ctrl;

    spq_pkg::t_spq_entry entries [DEPTH];
    logic                gts     [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_beat    = i_in_valid && !o_in_stall;
    assign is_pop     = (i_in_data.opcode == spq_pkg::OP_POP);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        ctrl.push      = in_beat && !is_pop && !full;
        ctrl.pop       = in_beat && is_pop && !empty;
        ctrl.item.prio = i_in_data.priority_req;
        ctrl.item.tag  = i_in_data.item_tag;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            spq_pkg::t_spq_entry left_entry;
            spq_pkg::t_spq_entry right_entry;
            logic                left_gt;

            if (gi == 0) begin : g_head
                assign left_entry = '0;
                assign left_gt    = 1'b1;
            end else begin : g_mid
                assign left_entry = entries[gi-1];
                assign left_gt    = gts[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_entry = '0;
            end else begin : g_body
                assign right_entry = entries[gi+1];
            end

            spq_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (ctrl),
                .i_occ     (CNT_W'(gi) < r_count),
                .i_left    (left_entry),
                .i_left_gt (left_gt),
                .i_right   (right_entry),
                .o_entry   (entries[gi]),
                .o_gt      (gts[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count_wide = WIDE_W'(n_count);

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (in_beat) begin
            n_out_valid        = 1'b1;
            n_out.status       = spq_pkg::ST_OK;
            n_out.out_tag      = '0;
            n_out.out_priority = '0;
            n_out.count        = count_wide[spq_pkg::COUNT_W-1:0];
            if (is_pop) begin
                if (empty) begin
                    n_out.status = spq_pkg::ST_POP_EMPTY;
                end else begin
                    n_out.out_tag      = entries[0].tag;
                    n_out.out_priority = entries[0].prio;
                end
            end else if (full) begin
                n_out.status = spq_pkg::ST_PUSH_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/spq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_spq_ctrl  i_ctrl,
    input  logic                i_occ,       // slot holds a live entry
    input  spq_pkg::t_spq_entry i_left,      // entry one place toward the head
    input  logic                i_left_gt,   // left slot stays put on a push
    input  spq_pkg::t_spq_entry i_right,     // entry one place toward the tail
    output spq_pkg::t_spq_entry o_entry,
    output logic                o_gt
);

    spq_pkg::t_spq_entry r_entry;
    spq_pkg::t_spq_entry n_entry;

    // Live entry strictly above the pushed priority stays where it is
    assign o_gt = i_occ && (r_entry.prio > i_ctrl.item.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            if (!o_gt) begin
                n_entry = i_left_gt ? i_ctrl.item : i_left;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
